>>> src/jsu_pkg.sv
// Shared types, constants and encoding functions for the JSON string unescaper.
package jsu_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] HI_SUR_LO = 16'hD800;
    localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SUR_LO = 16'hDC00;
    localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_BODY    = 4'd1,
        M_ESC     = 4'd2,
        M_HEX     = 4'd3,
        M_HIGH    = 4'd4,
        M_HIGH_BS = 4'd5,
        M_HEX_LO  = 4'd6
    } t_mode;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
    } t_enc;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            done;
        logic            err;
    } t_group;

    function automatic t_enc utf8_enc(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp < 21'h80) begin
            e.bytes[0] = cp[7:0];
            e.nbytes   = 3'd1;
        end else if (cp < 21'h800) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.nbytes   = 3'd2;
        end else if (cp < 21'h10000) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.nbytes   = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.nbytes   = 3'd4;
        end
        return e;
    endfunction

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // {ok, byte} for the single-byte escapes
    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_QUOTE: r = {1'b1, CH_QUOTE};
            CH_BSL:   r = {1'b1, CH_BSL};
            CH_SLASH: r = {1'b1, CH_SLASH};
            CH_B:     r = {1'b1, 8'h08};
            CH_F:     r = {1'b1, 8'h0C};
            CH_N:     r = {1'b1, 8'h0A};
            CH_R:     r = {1'b1, 8'h0D};
            CH_T:     r = {1'b1, 8'h09};
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> src/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: decoder, group queue and serializer.
// Decodes one quoted JSON string, one raw byte per pushed word, into UTF-8 bytes.
// A byte is accepted every cycle while the four-entry group queue has room; the
// decoder finishes each byte in the cycle it is accepted. Each byte yields zero to
// four result words, which leave the serializer one per cycle while they are popped.
// Errors and the closing quote return the decoder to idle; the next byte must be an
// opening quote.
module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_input_ends,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_string_done,
    output logic       o_error_flag,
    output logic       o_last_of_run
);
    import jsu_pkg::*;

    logic   accept;
    logic   q_push, q_pop, q_full, q_nonempty;
    t_group f_grp, q_head;

    assign full   = q_full;
    assign accept = push && !q_full;

    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_input_ends (i_input_ends),
        .o_push       (q_push),
        .o_grp        (f_grp)
    );

    jsu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_grp      (f_grp),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nonempty  (q_nonempty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_string_done (o_string_done),
        .o_error_flag  (o_error_flag),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTHESIS
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_flag) |-> o_last_of_run)
        else $error("error word not last of its run");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_string_done) |-> (o_last_of_run && !o_byte_valid))
        else $error("done word not last or carries a byte");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> $onehot({o_byte_valid, o_string_done, o_error_flag}))
        else $error("result word has no single kind");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("group queue written while full");
`endif

endmodule

>>> src/jsu_front.sv
// Byte decoder: tracks the escape state and builds at most one result group per byte.
module jsu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_input_ends,
    output logic            o_push,
    output jsu_pkg::t_group o_grp
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_held, n_held;

    t_group     g;
    t_enc       e;
    logic [4:0] hd;
    logic [8:0] em;
    logic [15:0] v;
    logic [7:0] c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hex  <= '0;
            r_cnt  <= '0;
            r_held <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cnt  <= n_cnt;
            r_held <= n_held;
        end
    end

    always_comb begin
        c      = i_data_byte;
        n_mode = r_mode;
        n_hex  = r_hex;
        n_cnt  = r_cnt;
        n_held = r_held;
        g      = '0;
        hd     = hex_digit(c);
        em     = esc_map(c);
        v      = {r_hex[11:0], hd[3:0]};
        e      = '0;
        if (i_input_ends) begin
            g.err = 1'b1;
        end else begin
            case (r_mode)
                M_IDLE: begin
                    if (c == CH_QUOTE) n_mode = M_BODY;
                    else g.err = 1'b1;
                end
                M_BODY: begin
                    if (c == CH_QUOTE) begin
                        g.done = 1'b1;
                        n_mode = M_IDLE;
                    end else if (c == CH_BSL) begin
                        n_mode = M_ESC;
                    end else if (c < CH_SPACE) begin
                        g.err = 1'b1;
                    end else begin
                        g.bytes[0] = c;
                        g.nbytes   = 3'd1;
                    end
                end
                M_ESC: begin
                    if (c == CH_U) begin
                        n_mode = M_HEX;
                        n_hex  = '0;
                        n_cnt  = '0;
                    end else if (em[8]) begin
                        g.bytes[0] = em[7:0];
                        g.nbytes   = 3'd1;
                        n_mode     = M_BODY;
                    end else begin
                        g.err = 1'b1;
                    end
                end
                M_HEX, M_HEX_LO: begin
                    if (!hd[4]) begin
                        g.err = 1'b1;
                    end else if (r_cnt != 2'd3) begin
                        n_hex = v;
                        n_cnt = r_cnt + 2'd1;
                    end else begin
                        n_hex  = '0;
                        n_cnt  = '0;
                        n_mode = M_BODY;
                        if (r_mode == M_HEX_LO) begin
                            n_held = '0;
                            if (v >= LO_SUR_LO && v <= LO_SUR_HI) begin
                                e = utf8_enc(SUPP_BASE + {1'b0, r_held, v[9:0]});
                            end else begin
                                e = utf8_enc({5'd0, 16'hFFFD});
                            end
                        end else if (v >= HI_SUR_LO && v <= HI_SUR_HI) begin
                            n_held = v[9:0];
                            n_mode = M_HIGH;
                        end else if (v != 16'd0) begin
                            e = utf8_enc({5'd0, v});
                        end
                        g.bytes  = e.bytes;
                        g.nbytes = e.nbytes;
                    end
                end
                M_HIGH: begin
                    if (c == CH_BSL) begin
                        n_mode = M_HIGH_BS;
                    end else begin
                        n_held   = '0;
                        g.bytes  = {8'h00, REPL_B2, REPL_B1, REPL_B0};
                        g.nbytes = 3'd3;
                        n_mode   = M_BODY;
                        if (c == CH_QUOTE) begin
                            g.done = 1'b1;
                            n_mode = M_IDLE;
                        end else if (c < CH_SPACE) begin
                            g.err = 1'b1;
                        end else begin
                            g.bytes[3] = c;
                            g.nbytes   = 3'd4;
                        end
                    end
                end
                M_HIGH_BS: begin
                    if (c == CH_U) begin
                        n_mode = M_HEX_LO;
                        n_hex  = '0;
                        n_cnt  = '0;
                    end else if (em[8]) begin
                        n_held   = '0;
                        g.bytes  = {em[7:0], REPL_B2, REPL_B1, REPL_B0};
                        g.nbytes = 3'd4;
                        n_mode   = M_BODY;
                    end else begin
                        g.err = 1'b1;
                    end
                end
                default: begin
                    g.err = 1'b1;
                end
            endcase
        end
        if (g.err) begin
            g      = '0;
            g.err  = 1'b1;
            n_mode = M_IDLE;
            n_hex  = '0;
            n_cnt  = '0;
            n_held = '0;
        end else if (g.done) begin
            n_mode = M_IDLE;
            n_hex  = '0;
            n_cnt  = '0;
            n_held = '0;
        end
    end

    assign o_grp  = g;
    assign o_push = i_accept && (g.err || g.done || (g.nbytes != 3'd0));

endmodule

>>> src/jsu_queue.sv
// Short queue of result groups between the decoder and the serializer.
module jsu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_group i_grp,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output jsu_pkg::t_group o_head
);
    import jsu_pkg::*;

    t_group         r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QAW'(1);
            if (i_pop)  r_rd <= r_rd + QAW'(1);
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    assign o_full     = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];

endmodule

>>> src/jsu_back.sv
// Serializer: holds one group and hands out its result words one at a time.
module jsu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_nonempty,
    input  jsu_pkg::t_group i_q_head,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_string_done,
    output logic            o_error_flag,
    output logic            o_last_of_run
);
    import jsu_pkg::*;

    t_group     r_grp;
    logic       r_valid;
    logic [1:0] r_idx;
    logic [2:0] total;
    logic [1:0] last_idx;
    logic       is_last;
    logic       load;

    assign total    = r_grp.nbytes + {2'b00, r_grp.done};
    assign last_idx = r_grp.err ? 2'd0 : 2'(total - 3'd1);
    assign is_last  = (r_idx == last_idx);
    assign load     = !r_valid || (i_pop && is_last);
    assign o_q_pop  = load && i_q_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_q_nonempty;
            r_idx   <= '0;
        end else if (i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_grp <= i_q_head;
        end
    end

    always_comb begin
        o_out_byte    = '0;
        o_byte_valid  = 1'b0;
        o_string_done = 1'b0;
        o_error_flag  = 1'b0;
        if (r_grp.err) begin
            o_error_flag = 1'b1;
        end else if ({1'b0, r_idx} < r_grp.nbytes) begin
            o_out_byte   = r_grp.bytes[r_idx];
            o_byte_valid = 1'b1;
        end else begin
            o_string_done = 1'b1;
        end
        o_last_of_run = is_last;
    end

    assign o_empty = !r_valid;

endmodule
